/* rtl/tkv_pkg.sv */
// tkv_pkg: shared types, codes and helpers for the two-key volume control
// used by tkv_key and two_key_volume_debounce_repeat; depends on nothing else
package tkv_pkg;

    // tick timer width and saturation value
    localparam int TIMER_BITS = 8;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    // width used when comparing timers against the 8-bit tick registers
    localparam int CMP_W = (TIMER_BITS > 8) ? TIMER_BITS : 8;

    // key positions in the port byte, active low
    localparam int DOWN_BIT = 6;
    localparam int UP_BIT   = 4;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_SAMPLES = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_TICKS     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_STEP      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLUME_MAX       = 3'd4;
    localparam int CFG_DATA_W = 8;

    // adjust kind codes
    localparam logic [1:0] ADJ_NONE = 2'd0;
    localparam logic [1:0] ADJ_DOWN = 2'd1;
    localparam logic [1:0] ADJ_UP   = 2'd2;

    // volume note codes
    localparam logic [1:0] NOTE_ORDINARY = 2'd0;
    localparam logic [1:0] NOTE_MUTED    = 2'd1;
    localparam logic [1:0] NOTE_AT_MAX   = 2'd2;

    // one poll tick
    typedef struct packed {
        logic [7:0] port_byte;
        logic       read_ok;
        logic [6:0] current_volume;
    } in_item_t;

    // one result
    typedef struct packed {
        logic [1:0] adjust_kind;
        logic [6:0] new_volume;
        logic [1:0] volume_note;
        logic       down_key_held;
        logic       up_key_held;
    } out_item_t;

    // per-key debounce and hold timing state
    typedef struct packed {
        logic                  level;
        logic [3:0]            diff_count;
        logic [TIMER_BITS-1:0] since_press;
        logic [TIMER_BITS-1:0] since_repeat;
    } key_state_t;

    // saturating tick increment
    function automatic logic [TIMER_BITS-1:0] timer_tick(input logic [TIMER_BITS-1:0] t);
        return (t == TIMER_MAX) ? TIMER_MAX : t + {{(TIMER_BITS-1){1'b0}}, 1'b1};
    endfunction

endpackage

/* rtl/two_key_volume_debounce_repeat.sv */
// two_key_volume_debounce_repeat: each input transaction passes through the input register,
// a single combinational step that also updates the key state, and the result register;
// throughput one transaction per cycle while the result side is not stalled
// reset (aresetn low, synchronous) clears both pipeline valid bits, the key state
// and the primed flag, and restores configuration to 2, 23, 6, 5 and 100
// top level; depends on tkv_pkg and tkv_key
module two_key_volume_debounce_repeat (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  tkv_pkg::in_item_t                   s_data,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output tkv_pkg::out_item_t                  m_data,
    // configuration channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tkv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tkv_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    // configuration registers
    logic [3:0] debounce_samples_reg;
    logic [7:0] long_press_ticks_reg;
    logic [7:0] repeat_ticks_reg;
    logic [6:0] volume_step_reg;
    logic [6:0] volume_max_reg;

    // pipeline registers
    logic               in_valid_reg;
    tkv_pkg::in_item_t  in_data_reg;
    logic               out_valid_reg;
    tkv_pkg::out_item_t out_data_reg;
    tkv_pkg::out_item_t out_data_next;

    // key state
    logic                primed_reg;
    logic                primed_next;
    tkv_pkg::key_state_t down_reg;
    tkv_pkg::key_state_t up_reg;
    tkv_pkg::key_state_t down_key;
    tkv_pkg::key_state_t up_key;
    tkv_pkg::key_state_t down_next;
    tkv_pkg::key_state_t up_next;

    logic       advance;
    logic       step_en;
    logic [3:0] need;
    logic       down_press;
    logic       up_press;
    logic       down_due;
    logic       up_due;
    logic [1:0] kind;
    logic [6:0] vol_clamped;
    logic [6:0] vol_dec;
    logic [7:0] vol_sum;
    logic [6:0] vol_inc;
    logic [6:0] vol_final;
    logic [1:0] note;

    // handshake: result register frees up when taken, input register feeds it
    assign advance   = !out_valid_reg || m_ready;
    assign s_ready   = !in_valid_reg || advance;
    assign step_en   = advance && in_valid_reg;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;
    assign cfg_ready = 1'b1;

    // debounce of zero behaves as one
    assign need = (debounce_samples_reg == 4'd0) ? 4'd1 : debounce_samples_reg;

    // per-key debounce
    tkv_key u_down_key (
        .primed  (primed_reg),
        .read_ok (in_data_reg.read_ok),
        .sample  (in_data_reg.port_byte[tkv_pkg::DOWN_BIT]),
        .need    (need),
        .cur     (down_reg),
        .nxt     (down_key),
        .press   (down_press)
    );

    tkv_key u_up_key (
        .primed  (primed_reg),
        .read_ok (in_data_reg.read_ok),
        .sample  (in_data_reg.port_byte[tkv_pkg::UP_BIT]),
        .need    (need),
        .cur     (up_reg),
        .nxt     (up_key),
        .press   (up_press)
    );

    assign primed_next = primed_reg || in_data_reg.read_ok;

    // auto repeat due checks
    assign down_due = (tkv_pkg::CMP_W'(down_key.since_press) >=
                       tkv_pkg::CMP_W'(long_press_ticks_reg)) &&
                      (tkv_pkg::CMP_W'(down_key.since_repeat) >=
                       tkv_pkg::CMP_W'(repeat_ticks_reg));
    assign up_due   = (tkv_pkg::CMP_W'(up_key.since_press) >=
                       tkv_pkg::CMP_W'(long_press_ticks_reg)) &&
                      (tkv_pkg::CMP_W'(up_key.since_repeat) >=
                       tkv_pkg::CMP_W'(repeat_ticks_reg));

    // step selection: press down, press up, then repeat down, repeat up
    always_comb begin
        kind      = tkv_pkg::ADJ_NONE;
        down_next = down_key;
        up_next   = up_key;
        priority if (down_press && up_reg.level) begin
            kind = tkv_pkg::ADJ_DOWN;
        end else if (up_press && down_key.level) begin
            kind = tkv_pkg::ADJ_UP;
        end else if (primed_reg && in_data_reg.read_ok && !down_key.level &&
                     up_key.level && down_due) begin
            kind                   = tkv_pkg::ADJ_DOWN;
            down_next.since_repeat = '0;
        end else if (primed_reg && in_data_reg.read_ok && !up_key.level &&
                     down_key.level && up_due) begin
            kind                 = tkv_pkg::ADJ_UP;
            up_next.since_repeat = '0;
        end else begin
            kind = tkv_pkg::ADJ_NONE;
        end
    end

    // volume arithmetic with saturation
    assign vol_clamped = (in_data_reg.current_volume > volume_max_reg) ?
                         volume_max_reg : in_data_reg.current_volume;
    assign vol_dec     = (vol_clamped > volume_step_reg) ?
                         vol_clamped - volume_step_reg : 7'd0;
    assign vol_sum     = {1'b0, vol_clamped} + {1'b0, volume_step_reg};
    assign vol_inc     = (vol_sum > {1'b0, volume_max_reg}) ? volume_max_reg : vol_sum[6:0];

    always_comb begin
        unique case (kind)
            tkv_pkg::ADJ_DOWN: vol_final = vol_dec;
            tkv_pkg::ADJ_UP:   vol_final = vol_inc;
            default:           vol_final = vol_clamped;
        endcase
    end

    // note only after a step
    always_comb begin
        priority if (kind == tkv_pkg::ADJ_NONE) begin
            note = tkv_pkg::NOTE_ORDINARY;
        end else if (vol_final == 7'd0) begin
            note = tkv_pkg::NOTE_MUTED;
        end else if (vol_final == volume_max_reg) begin
            note = tkv_pkg::NOTE_AT_MAX;
        end else begin
            note = tkv_pkg::NOTE_ORDINARY;
        end
    end

    always_comb begin
        out_data_next.adjust_kind   = kind;
        out_data_next.new_volume    = vol_final;
        out_data_next.volume_note   = note;
        out_data_next.down_key_held = !down_next.level;
        out_data_next.up_key_held   = !up_next.level;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_samples_reg <= 4'd2;
            long_press_ticks_reg <= 8'd23;
            repeat_ticks_reg     <= 8'd6;
            volume_step_reg      <= 7'd5;
            volume_max_reg       <= 7'd100;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tkv_pkg::CFG_DEBOUNCE_SAMPLES: debounce_samples_reg <= cfg_wdata[3:0];
                tkv_pkg::CFG_LONG_PRESS_TICKS: long_press_ticks_reg <= cfg_wdata[7:0];
                tkv_pkg::CFG_REPEAT_TICKS:     repeat_ticks_reg     <= cfg_wdata[7:0];
                tkv_pkg::CFG_VOLUME_STEP:      volume_step_reg      <= cfg_wdata[6:0];
                tkv_pkg::CFG_VOLUME_MAX:       volume_max_reg       <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            out_data_reg <= out_data_next;
        end
    end

    // key state update, one tick per transaction
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            primed_reg <= 1'b0;
            down_reg   <= '{level: 1'b1, diff_count: 4'd0, since_press: '0, since_repeat: '0};
            up_reg     <= '{level: 1'b1, diff_count: 4'd0, since_press: '0, since_repeat: '0};
        end else if (step_en) begin
            primed_reg <= primed_next;
            down_reg   <= down_next;
            up_reg     <= up_next;
        end
    end

endmodule

/* rtl/tkv_key.sv */
// tkv_key: debounce and hold timers for one active-low key, one tick per call
// depends on tkv_pkg
module tkv_key (
    input  logic               primed,
    input  logic               read_ok,
    input  logic               sample,
    input  logic [3:0]         need,
    input  tkv_pkg::key_state_t cur,
    output tkv_pkg::key_state_t nxt,
    output logic               press
);

    logic [3:0] cnt_inc;

    // saturating diff count
    assign cnt_inc = (cur.diff_count == 4'hF) ? 4'hF : cur.diff_count + 4'd1;

    // next key state for this tick
    always_comb begin
        nxt   = cur;
        press = 1'b0;
        if (!primed) begin
            if (read_ok) begin
                nxt.level        = sample;
                nxt.diff_count   = 4'd0;
                nxt.since_press  = '0;
                nxt.since_repeat = '0;
            end
        end else begin
            nxt.since_press  = tkv_pkg::timer_tick(cur.since_press);
            nxt.since_repeat = tkv_pkg::timer_tick(cur.since_repeat);
            if (read_ok) begin
                if (sample == cur.level) begin
                    nxt.diff_count = 4'd0;
                end else if (cnt_inc >= need) begin
                    nxt.level      = sample;
                    nxt.diff_count = 4'd0;
                    press          = !sample;
                end else begin
                    nxt.diff_count = cnt_inc;
                end
                // a confirmed press restarts the hold timing
                if (press) begin
                    nxt.since_press  = '0;
                    nxt.since_repeat = '0;
                end
            end
        end
    end

endmodule

/* rtl/tkv_checker.sv */
// tkv_checker: port-level assertions for two_key_volume_debounce_repeat
// depends on tkv_pkg; attached to the top level by the bind at the end of this file
module tkv_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input tkv_pkg::out_item_t m_data
);

    // reset empties the result side
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // a stalled result holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // only defined step codes
    a_kind_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.adjust_kind == tkv_pkg::ADJ_NONE ||
                     m_data.adjust_kind == tkv_pkg::ADJ_DOWN ||
                     m_data.adjust_kind == tkv_pkg::ADJ_UP))
        else $error("illegal adjust kind");

    // a note only follows a step
    a_note_needs_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.adjust_kind == tkv_pkg::ADJ_NONE |->
        m_data.volume_note == tkv_pkg::NOTE_ORDINARY)
        else $error("volume note without a step");

    // muted note means zero volume, at-max note means nonzero volume
    a_note_matches_volume: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.volume_note != tkv_pkg::NOTE_MUTED || m_data.new_volume == 7'd0) &&
                    (m_data.volume_note != tkv_pkg::NOTE_AT_MAX || m_data.new_volume != 7'd0))
        else $error("volume note disagrees with volume");

endmodule

bind two_key_volume_debounce_repeat tkv_checker u_tkv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
